>>> rtl/u8sd_pkg.sv
// shared types, constants and helper functions of the utf-8 stream decoder
package u8sd_pkg;

    localparam int ACC_W = 40;
    localparam int LEN_W = 3;

    // output mode codes
    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    localparam logic [31:0] REPLACEMENT_CHAR = 32'h0000_FFFD;
    localparam logic [15:0] HIGH_SURR_BASE   = 16'hD7C0; // 0xd800 minus 0x10000 >> 10
    localparam logic [5:0]  LOW_SURR_TOP     = 6'b110111; // 0xdc00 >> 10

    // one finished sequence on its way from front to back
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [LEN_W-1:0] len;
        logic             mode;
    } seq_entry_t;

    // number of following bytes announced by a lead byte
    function automatic logic [LEN_W-1:0] lead_class(input logic [7:0] b);
        logic [LEN_W-1:0] n;
        if (b < 8'hC0)
            n = 3'd0;
        else if (b < 8'hE0)
            n = 3'd1;
        else if (b < 8'hF0)
            n = 3'd2;
        else if (b < 8'hF8)
            n = 3'd3;
        else if (b < 8'hFC)
            n = 3'd4;
        else
            n = 3'd5;
        return n;
    endfunction

    // marker bits stacked up by the shifted lead and following bytes
    function automatic logic [31:0] seq_offset(input logic [LEN_W-1:0] len);
        logic [31:0] o;
        unique case (len)
            3'd0:    o = 32'h0000_0000;
            3'd1:    o = 32'h0000_3080;
            3'd2:    o = 32'h000E_2080;
            3'd3:    o = 32'h03C8_2080;
            3'd4:    o = 32'hFA08_2080;
            default: o = 32'h8208_2080;
        endcase
        return o;
    endfunction

endpackage

>>> rtl/utf8_stream_decoder_unit.sv
// top level of the utf-8 stream decoder: front end, sequence queue and back end
// Takes one utf-8 byte per cycle and turns each completed sequence into one utf-32 value
// or one or two utf-16 code units; a surrogate pair gives a high and then a low unit, one
// unit a cycle while popped. A result passes through the queue and the output register
// before it reaches the result ports. Input stalls (full) only when the QUEUE_DEPTH-entry
// queue between the front end and the back end is full, which happens only while surrogate
// pairs or a stalled result side drain it. The mode is sampled when a sequence completes.
module utf8_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] code_unit,
    output logic        last_of_run,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import u8sd_pkg::*;

    logic       accept;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    seq_entry_t q_wdata;
    seq_entry_t q_rdata;

    assign full   = q_full;
    assign accept = push && !q_full;

    u8sd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_buffer (end_of_buffer),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    u8sd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_rdata),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .code_unit   (code_unit),
        .last_of_run (last_of_run)
    );

    // front never writes a finished sequence into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("sequence pushed into full queue");

    // low surrogate follows the high one with no gap
    a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=> !empty)
        else $error("second unit of surrogate pair missing");

    // a non-final unit is always a high surrogate
    a_high_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_of_run) |-> (code_unit[31:10] == 22'h36))
        else $error("non-final unit outside high surrogate range");

endmodule

>>> rtl/u8sd_front.sv
// front end: takes bytes, tracks the open sequence and hands finished ones to the queue
module u8sd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                end_of_buffer,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output logic                q_push,
    output u8sd_pkg::seq_entry_t q_data
);
    import u8sd_pkg::*;

    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             mode_reg, mode_next;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] cur_rem;
    logic [ACC_W-1:0] cur_acc;

    always_comb
    begin
        mode_next = cfg_we ? cfg_wdata : mode_reg;
        if (rem_reg == '0)
        begin
            cur_len = lead_class(in_byte);
            cur_rem = cur_len;
            cur_acc = {{(ACC_W-8){1'b0}}, in_byte};
        end
        else
        begin
            cur_len = len_reg;
            cur_rem = rem_reg - LEN_W'(1);
            cur_acc = {acc_reg[ACC_W-7:0], 6'b0} + {{(ACC_W-8){1'b0}}, in_byte};
        end

        rem_next = rem_reg;
        len_next = len_reg;
        acc_next = acc_reg;
        q_push   = 1'b0;
        if (accept)
        begin
            if (cur_rem != '0)
            begin
                if (end_of_buffer)
                begin
                    // unfinished sequence at buffer end is dropped
                    rem_next = '0;
                    len_next = '0;
                    acc_next = '0;
                end
                else
                begin
                    rem_next = cur_rem;
                    len_next = cur_len;
                    acc_next = cur_acc;
                end
            end
            else
            begin
                q_push   = 1'b1;
                rem_next = '0;
                len_next = '0;
                acc_next = '0;
            end
        end

        q_data.acc  = cur_acc;
        q_data.len  = cur_len;
        q_data.mode = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            len_reg  <= '0;
            acc_reg  <= '0;
            mode_reg <= MODE_UTF16;
        end
        else
        begin
            rem_reg  <= rem_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            mode_reg <= mode_next;
        end
    end

endmodule

>>> rtl/u8sd_queue.sv
// short queue of finished sequences between front and back
module u8sd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u8sd_pkg::seq_entry_t wdata,
    output logic                 full,
    input  logic                 pop,
    output u8sd_pkg::seq_entry_t rdata,
    output logic                 empty
);
    import u8sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seq_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/u8sd_back.sv
// back end: removes the marker offset, range checks and emits code units
module u8sd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u8sd_pkg::seq_entry_t q_data,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          code_unit,
    output logic                 last_of_run
);
    import u8sd_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_code_reg, out_code_next;
    logic              out_last_reg, out_last_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [15:0]       pend_code_reg, pend_code_next;
    logic              take;
    logic signed [ACC_W:0] v;
    logic              neg;
    logic [31:0]       first_code;
    logic              has_pair;
    logic [15:0]       high_unit;
    logic [15:0]       low_unit;

    always_comb
    begin
        v   = $signed({1'b0, q_data.acc}) - $signed({{(ACC_W-31){1'b0}}, seq_offset(q_data.len)});
        neg = v[ACC_W];

        high_unit = HIGH_SURR_BASE + {5'b0, v[20:10]};
        low_unit  = {LOW_SURR_TOP, v[9:0]};
        has_pair  = 1'b0;

        if (q_data.mode == MODE_UTF32)
        begin
            if (neg || v[ACC_W-1:31] == '0)
                first_code = v[31:0];
            else
                first_code = REPLACEMENT_CHAR;
        end
        else if (neg || v[ACC_W-1:16] == '0)
            first_code = {16'b0, v[15:0]};
        else if (v[ACC_W-1:21] != '0 || (v[20] && v[19:16] != '0))
            first_code = REPLACEMENT_CHAR;
        else
        begin
            first_code = {16'b0, high_unit};
            has_pair   = 1'b1;
        end

        // output register is free or being drained this cycle
        take  = !out_valid_reg || pop;
        q_pop = take && !pend_valid_reg && !q_empty;

        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        if (take)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = {16'b0, pend_code_reg};
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = first_code;
                out_last_next   = !has_pair;
                pend_valid_next = has_pair;
                pend_code_next  = low_unit;
            end
            else
                out_valid_next = 1'b0;
        end
    end

    assign empty       = !out_valid_reg;
    assign code_unit   = out_code_reg;
    assign last_of_run = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
        pend_code_reg <= pend_code_next;
    end

endmodule
